>>> rtl/core/autoscaled_false_colour_mapper_assert.svh
// Assertion macros shared by the false-colour mapper RTL
`ifndef AUTOSCALED_FALSE_COLOUR_MAPPER_ASSERT_SVH
`define AUTOSCALED_FALSE_COLOUR_MAPPER_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define ACFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger
`define ACFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/acfm_pkg.sv
// Types, constants and command codes of the false-colour mapper
`default_nettype none
package acfm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 36;
   localparam int SQSUM_W    = 52;
   localparam int CNT_W      = 21;
   localparam int LEVEL_W    = 19;
   localparam int SPAN_W     = 20;
   localparam int SCALE_W    = 32;
   localparam int DIV_W      = 52;
   localparam int DVSR_W     = 21;
   localparam int DIV_CNT_W  = 6;
   localparam int RAD_W      = 34;
   localparam int ROOT_W     = 17;
   localparam int SQ_REM_W   = 20;
   localparam int SQ_CNT_W   = 5;
   localparam int PROD_W     = 53;
   localparam int XQ_W       = 20;
   localparam int F_W        = 30;
   localparam int COL_W      = 32;

   localparam logic [CNT_W-1:0]     MAX_PIXELS = 21'd1048576;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = 6'd52;
   localparam logic [SQ_CNT_W-1:0]  SQ_STEPS   = 5'd17;
   localparam logic [15:0]          BIAS_RESET = 16'd1;

   // Palette breakpoints in units of 2^-16
   localparam logic signed [COL_W-1:0] K_R_UP  = 32'sd25493504;
   localparam logic signed [COL_W-1:0] K_R_DN  = 32'sd75694080;
   localparam logic signed [COL_W-1:0] K_G1_UP = 32'sd8716288;
   localparam logic signed [COL_W-1:0] K_G1_DN = 32'sd42205184;
   localparam logic signed [COL_W-1:0] K_G2_UP = 32'sd25690112;
   localparam logic signed [COL_W-1:0] K_G2_DN = 32'sd58982400;
   localparam logic signed [COL_W-1:0] K_B_UP  = 32'sd8323072;
   localparam logic signed [COL_W-1:0] K_B_DN  = 32'sd41943040;

   typedef struct packed {
      logic        cmd;
      logic [15:0] sample;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE      = 4'd0,
      OP_LOAD      = 4'd1,
      OP_SQUARE    = 4'd2,
      OP_ACCUM     = 4'd3,
      OP_DIV_START = 4'd4,
      OP_DIV_STEP  = 4'd5,
      OP_MEAN_SAVE = 4'd6,
      OP_VAR       = 4'd7,
      OP_SQRT_STEP = 4'd8,
      OP_LEVEL     = 4'd9,
      OP_FINISH    = 4'd10,
      OP_MAP_MUL   = 4'd11,
      OP_MAP_F     = 4'd12,
      OP_MAP_OUT   = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      DIV_MEAN  = 2'd0,
      DIV_MSQ   = 2'd1,
      DIV_SCALE = 2'd2
   } div_src_type;

   typedef struct packed {
      op_type      op;
      div_src_type src;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cmd;
      logic last;
      logic div_done;
      logic sqrt_done;
      logic count_zero;
      logic span_pos;
      logic rsp_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

>>> rtl/core/acfm_datapath.sv
// Datapath: accumulators, shared divider, square root, window and palette
`default_nettype none
module acfm_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [15:0]           csr_wdata,
   input  wire acfm_pkg::req_type     req_data,
   input  wire acfm_pkg::ctrl_cmd_type cmd,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output acfm_pkg::rsp_type          rsp_data,
   output acfm_pkg::dp_stat_type      stat
);
   import acfm_pkg::*;

   function automatic logic signed [LEVEL_W-1:0] clamp_level(input logic signed [20:0] v);
      logic signed [LEVEL_W-1:0] r;
      if (v > 21'sd262143)       r = 19'sd262143;
      else if (v < -21'sd262144) r = -19'sd262144;
      else                       r = v[LEVEL_W-1:0];
      return r;
   endfunction

   function automatic logic [7:0] to_byte(input logic signed [COL_W-1:0] v);
      logic [7:0] r;
      if (v[COL_W-1])    r = 8'd0;
      else if (|v[30:24]) r = 8'hFF;
      else               r = v[23:16];
      return r;
   endfunction

   function automatic logic signed [COL_W-1:0] smin(input logic signed [COL_W-1:0] a,
                                                     input logic signed [COL_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   req_type                    in_ff;
   logic [15:0]                bias_ff;
   logic [31:0]                sq_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [SQSUM_W-1:0]         sqsum_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [DIV_W-1:0]           quo_ff, quo_in;
   logic [DVSR_W-1:0]          rem_ff, rem_in, dvsr_ff;
   logic [DIV_CNT_W-1:0]       dcnt_ff;
   logic [15:0]                mean_ff;
   logic [31:0]                m2_ff;
   logic [RAD_W-1:0]           rad_ff;
   logic [ROOT_W-1:0]          root_ff;
   logic [SQ_REM_W-1:0]        sqrem_ff;
   logic [SQ_CNT_W-1:0]        scnt_ff;
   logic signed [LEVEL_W-1:0]  low_ff, high_ff;
   logic [SCALE_W-1:0]         scale_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [F_W-1:0]      f_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;

   logic [DVSR_W:0]            div_trial;
   logic signed [SPAN_W-1:0]   span;
   logic [32:0]                msq, var_v;
   logic [SQ_REM_W-1:0]        sq_sh, sq_trial;
   logic signed [20:0]         mean21, dev3, lo21, hi21;
   logic signed [SPAN_W-1:0]   diff;
   logic signed [37:0]         xsh;
   logic signed [XQ_W-1:0]     xq;
   logic signed [COL_W-1:0]    f32, col_r, col_g, col_b;
   logic [7:0]                 empty_c;

   // Status to the controller
   assign span     = SPAN_W'(high_ff) - SPAN_W'(low_ff);
   assign stat.cmd        = in_ff.cmd;
   assign stat.last       = in_ff.last;
   assign stat.div_done   = (dcnt_ff == '0);
   assign stat.sqrt_done  = (scnt_ff == '0);
   assign stat.count_zero = (count_ff == '0);
   assign stat.span_pos   = (high_ff > low_ff);
   assign stat.rsp_busy   = rsp_valid_ff & ~rsp_ready;

   // Hold input word and bias register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) in_ff <= req_data;
      if (reset)       bias_ff <= BIAS_RESET;
      else if (csr_we) bias_ff <= csr_wdata;
   end

   // Accumulate statistics, clear on pass close
   always_ff @(posedge clock) begin
      if (cmd.op == OP_SQUARE) sq_ff <= 32'(in_ff.sample) * 32'(in_ff.sample);
      if (reset || cmd.op == OP_FINISH) begin
         sum_ff   <= '0;
         sqsum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.op == OP_ACCUM && count_ff < MAX_PIXELS) begin
         sum_ff   <= sum_ff + SUM_W'(in_ff.sample);
         sqsum_ff <= sqsum_ff + SQSUM_W'(sq_ff);
         count_ff <= count_ff + 1'b1;
      end
   end

   // Restoring divider, one quotient bit per step
   always_comb begin
      div_trial = {rem_ff, quo_ff[DIV_W-1]};
      if (div_trial >= {1'b0, dvsr_ff}) begin
         rem_in = DVSR_W'(div_trial - {1'b0, dvsr_ff});
         quo_in = {quo_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_in = div_trial[DVSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.op == OP_DIV_START) begin
         dcnt_ff <= DIV_STEPS;
         rem_ff  <= '0;
         case (cmd.src)
            DIV_MEAN: begin
               quo_ff  <= DIV_W'(sum_ff);
               dvsr_ff <= count_ff;
            end
            DIV_MSQ: begin
               quo_ff  <= sqsum_ff;
               dvsr_ff <= count_ff;
            end
            default: begin
               quo_ff  <= DIV_W'(1) << 31;
               dvsr_ff <= DVSR_W'(span);
            end
         endcase
      end else if (cmd.op == OP_DIV_STEP) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   // Mean square plus bias minus squared mean, floored at zero
   assign msq   = {1'b0, quo_ff[31:0]} + 33'(bias_ff);
   assign var_v = (msq > 33'(m2_ff)) ? msq - 33'(m2_ff) : '0;

   // Square root, two radicand bits per step
   assign sq_sh    = {sqrem_ff[SQ_REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MEAN_SAVE) begin
         mean_ff <= quo_ff[15:0];
         m2_ff   <= quo_ff[15:0] * quo_ff[15:0];
      end
      if (reset) begin
         scnt_ff <= '0;
      end else if (cmd.op == OP_VAR) begin
         rad_ff   <= RAD_W'(var_v);
         root_ff  <= '0;
         sqrem_ff <= '0;
         scnt_ff  <= SQ_STEPS;
      end else if (cmd.op == OP_SQRT_STEP) begin
         scnt_ff <= scnt_ff - 1'b1;
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         if (sq_sh >= sq_trial) begin
            sqrem_ff <= sq_sh - sq_trial;
            root_ff  <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            sqrem_ff <= sq_sh;
            root_ff  <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Window levels and map scale
   assign mean21 = stat.count_zero ? '0 : 21'(mean_ff);
   assign dev3   = stat.count_zero ? '0 : 21'(root_ff) + 21'({root_ff, 1'b0});
   assign lo21   = mean21 - dev3;
   assign hi21   = mean21 + dev3;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= '0;
         high_ff  <= '0;
         scale_ff <= '0;
      end else if (cmd.op == OP_LEVEL) begin
         low_ff  <= clamp_level(lo21);
         high_ff <= clamp_level(hi21);
      end else if (cmd.op == OP_FINISH) begin
         scale_ff <= stat.span_pos ? quo_ff[SCALE_W-1:0] : '0;
      end
   end

   // Map: scale product, Q4.16 position, palette
   assign diff = SPAN_W'(in_ff.sample) - SPAN_W'(low_ff);
   assign xsh  = prod_ff[PROD_W-1:15];

   always_comb begin
      if (xsh > 38'sd524287)       xq = 20'sd524287;
      else if (xsh < -38'sd524288) xq = -20'sd524288;
      else                         xq = xsh[XQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MAP_MUL)
         prod_ff <= PROD_W'(diff) * $signed({21'b0, scale_ff});
      if (cmd.op == OP_MAP_F)
         f_ff <= F_W'(xq) * 30'sd1020;
   end

   assign f32   = COL_W'(f_ff);
   assign col_r = smin(f32 - K_R_UP, K_R_DN - f32);
   assign col_b = smin(f32 + K_B_UP, K_B_DN - f32);
   always_comb begin
      col_g = smin(f32 - K_G1_UP, K_G1_DN - f32);
      if (smin(f32 - K_G2_UP, K_G2_DN - f32) > col_g)
         col_g = smin(f32 - K_G2_UP, K_G2_DN - f32);
   end
   assign empty_c = ($signed({3'b0, in_ff.sample}) > high_ff) ? 8'hFF : 8'h00;

   // Output register
   always_ff @(posedge clock) begin
      if (reset)                   rsp_valid_ff <= 1'b0;
      else if (cmd.op == OP_MAP_OUT) rsp_valid_ff <= 1'b1;
      else if (rsp_ready)          rsp_valid_ff <= 1'b0;
      if (cmd.op == OP_MAP_OUT) begin
         if (stat.span_pos) begin
            rsp_ff.red   <= to_byte(col_r);
            rsp_ff.green <= to_byte(col_g);
            rsp_ff.blue  <= to_byte(col_b);
         end else begin
            rsp_ff.red   <= empty_c;
            rsp_ff.green <= empty_c;
            rsp_ff.blue  <= empty_c;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/core/acfm_ctrl.sv
// Controller: sequences accumulate, window close and map steps
`default_nettype none
module acfm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire acfm_pkg::dp_stat_type stat,
   output acfm_pkg::ctrl_cmd_type     cmd
);
   import acfm_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE      = 12'b000000000001,
      S_DISPATCH  = 12'b000000000010,
      S_ACCUM     = 12'b000000000100,
      S_CHECK     = 12'b000000001000,
      S_DIV_MEAN  = 12'b000000010000,
      S_MSQ_START = 12'b000000100000,
      S_DIV_MSQ   = 12'b000001000000,
      S_SQRT      = 12'b000010000000,
      S_SPAN      = 12'b000100000000,
      S_DIV_SCALE = 12'b001000000000,
      S_MAP_F     = 12'b010000000000,
      S_MAP_OUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      cmd.src  = DIV_MEAN;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.cmd) begin
               cmd.op   = OP_MAP_MUL;
               state_in = S_MAP_F;
            end else begin
               cmd.op   = OP_SQUARE;
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            cmd.op   = OP_ACCUM;
            state_in = stat.last ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            if (stat.count_zero) begin
               cmd.op   = OP_LEVEL;
               state_in = S_SPAN;
            end else begin
               cmd.op   = OP_DIV_START;
               state_in = S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (stat.div_done) begin
               cmd.op   = OP_MEAN_SAVE;
               state_in = S_MSQ_START;
            end else begin
               cmd.op = OP_DIV_STEP;
            end
         end
         S_MSQ_START: begin
            cmd.op   = OP_DIV_START;
            cmd.src  = DIV_MSQ;
            state_in = S_DIV_MSQ;
         end
         S_DIV_MSQ: begin
            cmd.src = DIV_MSQ;
            if (stat.div_done) begin
               cmd.op   = OP_VAR;
               state_in = S_SQRT;
            end else begin
               cmd.op = OP_DIV_STEP;
            end
         end
         S_SQRT: begin
            if (stat.sqrt_done) begin
               cmd.op   = OP_LEVEL;
               state_in = S_SPAN;
            end else begin
               cmd.op = OP_SQRT_STEP;
            end
         end
         S_SPAN: begin
            cmd.src = DIV_SCALE;
            if (stat.span_pos) begin
               cmd.op   = OP_DIV_START;
               state_in = S_DIV_SCALE;
            end else begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         S_DIV_SCALE: begin
            cmd.src = DIV_SCALE;
            if (stat.div_done) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_DIV_STEP;
            end
         end
         S_MAP_F: begin
            cmd.op   = OP_MAP_F;
            state_in = S_MAP_OUT;
         end
         S_MAP_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_MAP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/autoscaled_false_colour_mapper.sv
// Top level of the autoscaled false-colour mapper
// A frame goes through twice. Statistics words (cmd 0) are summed in turn;
// the word marked last also closes the pass: two 52-step divisions (mean and
// mean square), a 17-step square root and, for a non-empty window, a third
// 52-step division for the map scale. For map words (cmd 1), a scale
// multiply, the Q4.16 position multiply and the palette stage feed one
// output register, which lets the next word in while a pixel still waits on
// rsp_ready. The shared serial divider sets the length of the pass close.
// variance_bias is written through csr_we.
`default_nettype none
`include "autoscaled_false_colour_mapper_assert.svh"
module autoscaled_false_colour_mapper (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire acfm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output acfm_pkg::rsp_type      rsp_data
);
   import acfm_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   acfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   acfm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (ctrl_cmd),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (dp_stat)
   );

   // Busy right after taking a word
   `ACFM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   // A pixel only appears after the palette stage
   `ACFM_ASSERT_NOW(a_rsp_from_map, clock, reset, $rose(rsp_valid), $past(ctrl_cmd.op == OP_MAP_OUT), "pixel without map")
   // No datapath work while waiting for a word
   `ACFM_ASSERT_NOW(a_idle_quiet, clock, reset, req_ready, ctrl_cmd.op == OP_IDLE || ctrl_cmd.op == OP_LOAD, "work while idle")

endmodule
`default_nettype wire
